FILE: rtl/tolp_pkg.sv
// shared types, character codes and a digit helper for the target offset line parser
`timescale 1ns / 1ps
`default_nettype none

package tolp_pkg;

    // character codes
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int unsigned DZ_W   = 15;
    localparam int unsigned MAG_W  = 16;
    localparam logic [DZ_W-1:0] DZ_RESET = 15'd15;
    localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_P,
        KIND_CLEAR,
        KIND_D
    } line_kind_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_COLON,
        PH_N_START,
        PH_N_DIGITS,
        PH_X_START,
        PH_X_DIGITS,
        PH_IGNORE,
        PH_D_DIGIT
    } parse_phase_t;

    // per-line parse state plus the indicator
    typedef struct packed {
        line_kind_t        kind;
        parse_phase_t      phase;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [3:0]        digit;
        logic              digit_present;
        logic              led;
    } parse_state_t;

    // one result beat
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       led_lit;
        logic       blink_start;
        logic [3:0] blink_digit;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tolp_in_if.sv
// input channel: received byte with its error flag
`timescale 1ns / 1ps
`default_nettype none

interface tolp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_error;

    modport source (output valid, output rx_byte, output rx_error, input ready);
    modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/tolp_out_if.sv
// output channel: echo, indicator and blink request
`timescale 1ns / 1ps
`default_nettype none

interface tolp_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       led_lit;
    logic       blink_start;
    logic [3:0] blink_digit;

    modport source (output valid, output echo_valid, output echo_byte, output led_lit,
                    output blink_start, output blink_digit, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input led_lit,
                    input blink_start, input blink_digit, output ready);
endinterface

`default_nettype wire

FILE: rtl/tolp_parser.sv
// one-byte step of the line parser: next state and result beat
`timescale 1ns / 1ps
`default_nettype none

module tolp_parser
    import tolp_pkg::*;
#(
    parameter int unsigned POS_W = 6,
    parameter int unsigned LINE_CAPACITY = 64
)(
    input  wire logic [7:0]        rx_byte,
    input  wire logic              rx_error,
    input  wire logic [DZ_W-1:0]   dead_zone,
    input  wire logic [POS_W-1:0]  pos,
    input  wire parse_state_t      st,
    output logic [POS_W-1:0]       pos_next,
    output parse_state_t           st_next,
    output result_t                res
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

    logic [MAG_W+3:0] mag_acc;
    logic [3:0]       dval;

    assign dval    = rx_byte[3:0];
    assign mag_acc = {1'b0, st.mag, 3'b000} + {3'b000, st.mag, 1'b0}
                   + {{MAG_W{1'b0}}, dval};

    always_comb
    begin
        pos_next = pos;
        st_next  = st;
        res      = '0;

        if (rx_error)
        begin
            // drop the byte and restart the line, indicator kept
            pos_next              = '0;
            st_next               = '0;
            st_next.led           = st.led;
        end
        else
        begin
            res.echo_valid = 1'b1;
            res.echo_byte  = rx_byte;
            if (rx_byte == CH_CR)
            begin
                // carriage return skipped
            end
            else if (rx_byte == CH_LF)
            begin
                // end of line: act on what was parsed
                if (st.phase != PH_START && st.phase != PH_COLON)
                begin
                    if (st.kind == KIND_CLEAR)
                    begin
                        st_next.led = 1'b0;
                    end
                    else if (st.kind == KIND_P)
                    begin
                        if (st.phase == PH_N_START || st.phase == PH_N_DIGITS)
                            st_next.led = 1'b0;
                        else if (st.mag > {1'b0, dead_zone})
                            st_next.led = st.neg ? 1'b1 : ~st.led;
                        else
                            st_next.led = 1'b0;
                    end
                    else if (st.kind == KIND_D && st.digit_present)
                    begin
                        res.blink_start = 1'b1;
                        res.blink_digit = st.digit;
                        st_next.led     = 1'b0;
                    end
                end
                pos_next            = '0;
                st_next.kind          = KIND_NONE;
                st_next.phase         = PH_START;
                st_next.neg           = 1'b0;
                st_next.mag           = '0;
                st_next.digit         = '0;
                st_next.digit_present = 1'b0;
            end
            else if (pos < POS_LAST)
            begin
                pos_next = pos + 1'b1;
                // character parse
                case (st.phase)
                    PH_START:
                    begin
                        if (rx_byte == CH_P)
                            st_next.kind = KIND_P;
                        else if (rx_byte == CH_D)
                            st_next.kind = KIND_D;
                        else if (rx_byte == CH_A || rx_byte == CH_H || rx_byte == CH_N)
                            st_next.kind = KIND_CLEAR;
                        else
                            st_next.kind = KIND_NONE;
                        st_next.phase = (st_next.kind == KIND_NONE) ? PH_IGNORE : PH_COLON;
                    end
                    PH_COLON:
                    begin
                        if (rx_byte != CH_COLON)
                        begin
                            st_next.kind  = KIND_NONE;
                            st_next.phase = PH_IGNORE;
                        end
                        else if (st.kind == KIND_P)
                            st_next.phase = PH_N_START;
                        else if (st.kind == KIND_D)
                            st_next.phase = PH_D_DIGIT;
                        else
                            st_next.phase = PH_IGNORE;
                    end
                    PH_N_START, PH_N_DIGITS:
                    begin
                        if (rx_byte == CH_COMMA)
                            st_next.phase = PH_X_START;
                        else if (is_digit(rx_byte) || (st.phase == PH_N_START &&
                                 (rx_byte == CH_MINUS || rx_byte == CH_PLUS)))
                            st_next.phase = PH_N_DIGITS;
                        else
                        begin
                            st_next.kind  = KIND_CLEAR;
                            st_next.phase = PH_IGNORE;
                        end
                    end
                    PH_X_START:
                    begin
                        if (rx_byte == CH_MINUS)
                        begin
                            st_next.neg   = 1'b1;
                            st_next.phase = PH_X_DIGITS;
                        end
                        else if (rx_byte == CH_PLUS)
                            st_next.phase = PH_X_DIGITS;
                        else if (is_digit(rx_byte))
                        begin
                            st_next.mag   = {{(MAG_W-4){1'b0}}, dval};
                            st_next.phase = PH_X_DIGITS;
                        end
                        else
                            st_next.phase = PH_IGNORE;
                    end
                    PH_X_DIGITS:
                    begin
                        // saturating decimal accumulate
                        if (is_digit(rx_byte))
                            st_next.mag = (mag_acc[MAG_W+3:MAG_W] != 4'd0) ? MAG_MAX
                                                                          : mag_acc[MAG_W-1:0];
                        else
                            st_next.phase = PH_IGNORE;
                    end
                    PH_D_DIGIT:
                    begin
                        if (is_digit(rx_byte))
                        begin
                            st_next.digit         = dval;
                            st_next.digit_present = 1'b1;
                        end
                        st_next.phase = PH_IGNORE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                // line overflow: echoed, dropped, line restarts
                pos_next    = '0;
                st_next     = '0;
                st_next.led = st.led;
            end
        end
        res.led_lit = st_next.led;
    end

endmodule

`default_nettype wire

FILE: rtl/target_offset_line_parser.sv
// top level: input register, parser step, result register and dead zone register
`timescale 1ns / 1ps
`default_nettype none

// Parses received UART bytes, one beat per byte, and returns one result beat per
// byte: the echo, the indicator state after the byte and any blink request from a
// completed "D:d" line. A byte is held in an input register; the parser step
// updates the line state and writes the result register, so one byte is taken
// every cycle unless the output stalls; a stalled result holds the input side
// only while both registers are full. dead_zone (reset 15) is written through
// cfg_wr_en / cfg_wr_data; the user must write only while idle (not enforced).
// LINE_CAPACITY bounds the characters held in one line (4 to 256).
module target_offset_line_parser
    import tolp_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = 64
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [DZ_W-1:0] cfg_wr_data,
    tolp_in_if.sink              rx_ch,
    tolp_out_if.source           tx_ch
);

    localparam int unsigned POS_W = $clog2(LINE_CAPACITY);

    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_err_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    parse_state_t      st_reg;
    parse_state_t      st_next;
    logic [DZ_W-1:0]   dead_zone_reg;
    logic              out_free;
    logic              advance;

    // handshake between the two register stages
    assign out_free    = !out_valid_reg || tx_ch.ready;
    assign advance     = s1_valid_reg && out_free;
    assign rx_ch.ready = !s1_valid_reg || out_free;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dead_zone_reg <= DZ_RESET;
        else if (cfg_wr_en)
            dead_zone_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx_ch.ready)
            s1_valid_reg <= rx_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ch.valid && rx_ch.ready)
        begin
            s1_byte_reg <= rx_ch.rx_byte;
            s1_err_reg  <= rx_ch.rx_error;
        end
    end

    tolp_parser #(
        .POS_W         (POS_W),
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .rx_byte   (s1_byte_reg),
        .rx_error  (s1_err_reg),
        .dead_zone (dead_zone_reg),
        .pos       (pos_reg),
        .st        (st_reg),
        .pos_next  (pos_next),
        .st_next   (st_next),
        .res       (res)
    );

    // line state, updated as each beat moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            st_reg  <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            st_reg  <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign tx_ch.valid       = out_valid_reg;
    assign tx_ch.echo_valid  = out_reg.echo_valid;
    assign tx_ch.echo_byte   = out_reg.echo_byte;
    assign tx_ch.led_lit     = out_reg.led_lit;
    assign tx_ch.blink_start = out_reg.blink_start;
    assign tx_ch.blink_digit = out_reg.blink_digit;

    // a blink request always leaves the indicator dark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.blink_start |-> !out_reg.led_lit)
        else $error("blink beat with indicator lit");

    // an errored byte is never echoed
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_err_reg |=> out_valid_reg && !out_reg.echo_valid)
        else $error("errored byte echoed");

    // an errored byte restarts the line
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_err_reg |=> pos_reg == '0 && st_reg.phase == PH_START)
        else $error("line not restarted after receive error");

    // blink digit is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.blink_start |-> out_reg.blink_digit <= 4'd9)
        else $error("blink digit out of range");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the target offset line parser
`timescale 1ns / 1ps

module testbench;
    import tolp_pkg::*;

    localparam int unsigned LINE_CAP      = 64;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          ITEMS_PER_SET = 192;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          REPORT_MAX    = 10;

    // one row of the directed byte sequence
    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;
    localparam int      STIM_ROWS = 24;

    // reset checks, a receive error, byte extremes, a lit line, missing colon, malformed line, blink
    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, result_t'{1'b0, 8'h00, 1'b0, 1'b0, 4'd0}},
        '{8'h00, 1'b0, 1'b1, result_t'{1'b1, 8'h00, 1'b0, 1'b0, 4'd0}},
        '{8'hFF, 1'b0, 1'b1, result_t'{1'b1, 8'hFF, 1'b0, 1'b0, 4'd0}},
        '{CH_CR, 1'b0, 1'b1, result_t'{1'b1, CH_CR, 1'b0, 1'b0, 4'd0}},
        '{CH_LF, 1'b0, 1'b1, result_t'{1'b1, CH_LF, 1'b0, 1'b0, 4'd0}},
        // P:1,-99 lights the indicator
        '{CH_P, 1'b0, 1'b0, NO_RESULT},
        '{CH_COLON, 1'b0, 1'b0, NO_RESULT},
        '{8'h31, 1'b0, 1'b0, NO_RESULT},
        '{CH_COMMA, 1'b0, 1'b0, NO_RESULT},
        '{CH_MINUS, 1'b0, 1'b0, NO_RESULT},
        '{8'h39, 1'b0, 1'b0, NO_RESULT},
        '{8'h39, 1'b0, 1'b0, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, result_t'{1'b1, CH_LF, 1'b1, 1'b0, 4'd0}},
        // P9 has no colon and leaves the indicator alone
        '{CH_P, 1'b0, 1'b0, NO_RESULT},
        '{8'h39, 1'b0, 1'b0, NO_RESULT},
        '{CH_LF, 1'b0, 1'b0, NO_RESULT},
        // P:x is malformed and clears
        '{CH_P, 1'b0, 1'b0, NO_RESULT},
        '{CH_COLON, 1'b0, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, 1'b0, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, result_t'{1'b1, CH_LF, 1'b0, 1'b0, 4'd0}},
        // D:9 asks for a blink of nine
        '{CH_D, 1'b0, 1'b0, NO_RESULT},
        '{CH_COLON, 1'b0, 1'b0, NO_RESULT},
        '{8'h39, 1'b0, 1'b0, NO_RESULT},
        '{CH_LF, 1'b0, 1'b1, result_t'{1'b1, CH_LF, 1'b0, 1'b1, 4'd9}}
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [DZ_W-1:0] cfg_wr_data;

    tolp_in_if  rx_ch ();
    tolp_out_if tx_ch ();

    target_offset_line_parser #(
        .LINE_CAPACITY (LINE_CAP)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_ch       (rx_ch),
        .tx_ch       (tx_ch)
    );

    // line parser mirror
    line_kind_t      ln_kind;
    parse_phase_t    ln_phase;
    logic            ln_neg;
    int unsigned     ln_mag;
    logic [3:0]      ln_digit;
    logic            ln_has_digit;
    int unsigned     ln_len;
    logic            led_state;
    logic [DZ_W-1:0] dz_now;

    result_t    expected_beats[$];
    logic [7:0] line_buf[$];

    int n_items     = 0;
    int n_rx_errors = 0;
    int n_overflows = 0;
    int n_blinks    = 0;
    int n_led_on    = 0;
    int n_dz_sets   = 1;
    int n_mismatch  = 0;
    int burst_left  = 0;

    int          stall_mode   = 0;
    int          stall_left   = 0;
    int          stall_tick   = 0;
    logic [15:0] stall_bits   = 16'h00FF;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        rx_ch.rx_error  = 1'b0;
        tx_ch.ready     = 1'b0;
    end

    function automatic logic dec_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void clear_line();
        ln_kind      = KIND_NONE;
        ln_phase     = PH_START;
        ln_neg       = 1'b0;
        ln_mag       = 0;
        ln_digit     = '0;
        ln_has_digit = 1'b0;
        ln_len       = 0;
    endfunction

    // one character inside a line
    function automatic void advance_phase(input logic [7:0] c);
        int unsigned m;
        case (ln_phase)
            PH_START:
            begin
                if (c == CH_P)
                    ln_kind = KIND_P;
                else if (c == CH_D)
                    ln_kind = KIND_D;
                else if (c == CH_A || c == CH_H || c == CH_N)
                    ln_kind = KIND_CLEAR;
                else
                    ln_kind = KIND_NONE;
                ln_phase = (ln_kind == KIND_NONE) ? PH_IGNORE : PH_COLON;
            end
            PH_COLON:
            begin
                if (c != CH_COLON)
                begin
                    ln_kind  = KIND_NONE;
                    ln_phase = PH_IGNORE;
                end
                else if (ln_kind == KIND_P)
                    ln_phase = PH_N_START;
                else if (ln_kind == KIND_D)
                    ln_phase = PH_D_DIGIT;
                else
                    ln_phase = PH_IGNORE;
            end
            PH_N_START, PH_N_DIGITS:
            begin
                if (c == CH_COMMA)
                    ln_phase = PH_X_START;
                else if (dec_char(c) ||
                         (ln_phase == PH_N_START && (c == CH_MINUS || c == CH_PLUS)))
                    ln_phase = PH_N_DIGITS;
                else
                begin
                    ln_kind  = KIND_CLEAR;
                    ln_phase = PH_IGNORE;
                end
            end
            PH_X_START:
            begin
                if (c == CH_MINUS)
                begin
                    ln_neg   = 1'b1;
                    ln_phase = PH_X_DIGITS;
                end
                else if (c == CH_PLUS)
                    ln_phase = PH_X_DIGITS;
                else if (dec_char(c))
                begin
                    ln_mag   = c - CH_ZERO;
                    ln_phase = PH_X_DIGITS;
                end
                else
                    ln_phase = PH_IGNORE;
            end
            PH_X_DIGITS:
            begin
                if (dec_char(c))
                begin
                    // magnitude saturates rather than wrapping
                    m      = ln_mag * 10 + (c - CH_ZERO);
                    ln_mag = (m > MAG_MAX) ? MAG_MAX : m;
                end
                else
                    ln_phase = PH_IGNORE;
            end
            PH_D_DIGIT:
            begin
                if (dec_char(c))
                begin
                    ln_digit     = 4'(c - CH_ZERO);
                    ln_has_digit = 1'b1;
                end
                ln_phase = PH_IGNORE;
            end
            default:
            begin
            end
        endcase
    endfunction

    // expected result beat for one received byte
    function automatic result_t parse_byte(input logic [7:0] c, input logic err);
        result_t r;
        r = '0;
        if (err)
            clear_line();
        else
        begin
            r.echo_valid = 1'b1;
            r.echo_byte  = c;
            if (c == CH_LF)
            begin
                if (ln_phase != PH_START && ln_phase != PH_COLON)
                begin
                    case (ln_kind)
                        KIND_CLEAR:
                            led_state = 1'b0;
                        KIND_P:
                        begin
                            if (ln_phase == PH_N_START || ln_phase == PH_N_DIGITS)
                                led_state = 1'b0;
                            else if (ln_mag > dz_now)
                                led_state = ln_neg ? 1'b1 : ~led_state;
                            else
                                led_state = 1'b0;
                        end
                        KIND_D:
                        begin
                            if (ln_has_digit)
                            begin
                                r.blink_start = 1'b1;
                                r.blink_digit = ln_digit;
                                led_state     = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                clear_line();
            end
            else if (c != CH_CR)
            begin
                if (ln_len < LINE_CAP - 1)
                begin
                    advance_phase(c);
                    ln_len++;
                end
                else
                begin
                    n_overflows++;
                    clear_line();
                end
            end
        end
        r.led_lit = led_state;
        return r;
    endfunction

    // one input beat, with sender bursts and gaps
    task automatic send_beat(input logic [7:0] b, input logic err, input logic typed,
                             input result_t typed_res);
        result_t r;
        logic    led_before;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                rx_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        rx_ch.valid    <= 1'b1;
        rx_ch.rx_byte  <= b;
        rx_ch.rx_error <= err;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        burst_left--;
        led_before = led_state;
        r = parse_byte(b, err);
        if (r.blink_start)
            n_blinks++;
        if (r.led_lit && !led_before)
            n_led_on++;
        if (err)
            n_rx_errors++;
        n_items++;
        expected_beats.push_back(typed ? typed_res : r);
    endtask

    task automatic rx_idle();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
    endtask

    // dead zone write once every expected beat is back
    task automatic write_dead_zone(input logic [DZ_W-1:0] value);
        rx_idle();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dz_now = value;
        n_dz_sets++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic void put_sign();
        case ($urandom_range(0, 2))
            0: line_buf.push_back(CH_MINUS);
            1: line_buf.push_back(CH_PLUS);
            default:
            begin
            end
        endcase
    endfunction

    function automatic void put_num(input longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    // offset value aimed at the dead zone edges and saturation
    function automatic void put_offset();
        case ($urandom_range(0, 7))
            0: put_num(dz_now);
            1: put_num(dz_now + 1);
            2: put_num((dz_now > 0) ? dz_now - 1 : 0);
            3: put_num($urandom_range(0, 99999));
            4: put_num(MAG_MAX);
            5: put_num(65536 + $urandom_range(0, 1000000));
            6: put_num(64'd99999999999);
            default:
            begin
            end
        endcase
    endfunction

    // build one random line, mostly well formed
    function automatic void build_line();
        int pick;
        int n;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // position line
            line_buf.push_back(CH_P);
            line_buf.push_back(CH_COLON);
            put_sign();
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(rand_digit());
            line_buf.push_back(CH_COMMA);
            put_sign();
            put_offset();
            if ($urandom_range(0, 3) == 0)
                line_buf.push_back(rand_byte());
        end
        else if (pick < 50)
        begin
            // broken position line
            line_buf.push_back(CH_P);
            line_buf.push_back(CH_COLON);
            case ($urandom_range(0, 3))
                0:
                begin
                    line_buf.push_back(CH_MINUS);
                    line_buf.push_back(CH_PLUS);
                    line_buf.push_back(rand_digit());
                end
                1: put_num($urandom_range(0, 999));
                2: line_buf.push_back(rand_byte());
                default:
                begin
                    line_buf.push_back(rand_digit());
                    line_buf.push_back(CH_MINUS);
                    line_buf.push_back(rand_digit());
                    line_buf.push_back(CH_COMMA);
                    line_buf.push_back(rand_digit());
                end
            endcase
        end
        else if (pick < 65)
        begin
            // digit display line
            line_buf.push_back(CH_D);
            if ($urandom_range(0, 9) != 0)
                line_buf.push_back(CH_COLON);
            if ($urandom_range(0, 4) != 0)
                line_buf.push_back(rand_digit());
            else if ($urandom_range(0, 1) == 0)
                line_buf.push_back(rand_byte());
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n) line_buf.push_back(rand_byte());
        end
        else if (pick < 75)
        begin
            // clearing commands
            case ($urandom_range(0, 2))
                0: line_buf.push_back(CH_A);
                1: line_buf.push_back(CH_H);
                default: line_buf.push_back(CH_N);
            endcase
            if ($urandom_range(0, 4) != 0)
                line_buf.push_back(CH_COLON);
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(rand_byte());
        end
        else if (pick < 85)
        begin
            // unknown command or missing colon
            line_buf.push_back(rand_byte());
            if ($urandom_range(0, 1) == 0)
                line_buf.push_back(CH_COLON);
            n = $urandom_range(0, 5);
            repeat (n) line_buf.push_back(rand_byte());
        end
        else if (pick < 95)
        begin
            // raw noise
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(rand_byte());
        end
        else
        begin
            // long line that can run past capacity
            line_buf.push_back(CH_P);
            line_buf.push_back(CH_COLON);
            put_num($urandom_range(0, 99));
            line_buf.push_back(CH_COMMA);
            n = $urandom_range(55, 75);
            repeat (n) line_buf.push_back(rand_digit());
        end
        if ($urandom_range(0, 4) == 0)
            line_buf.push_back(CH_CR);
        if ($urandom_range(0, 19) != 0)
            line_buf.push_back(CH_LF);
    endfunction

    task automatic run_lines(input int target);
        int start;
        int err_at;
        start = n_items;
        while (n_items - start < target)
        begin
            build_line();
            err_at = ($urandom_range(0, 14) == 0) ?
                     $urandom_range(0, line_buf.size() - 1) : -1;
            foreach (line_buf[i])
                send_beat(line_buf[i], (i == err_at), 1'b0, NO_RESULT);
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 256);
            stall_bits = 16'($urandom) | 16'h0001;
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0: tx_ch.ready <= 1'b1;
            1: tx_ch.ready <= ($urandom_range(0, 3) != 0);
            2: tx_ch.ready <= stall_bits[stall_tick % 16];
            default: tx_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        n_mismatch++;
        if (n_mismatch <= REPORT_MAX)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            note_mismatch(what, want, got);
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (expected_beats.size() == 0)
                note_mismatch("unexpected result beat, echo_byte", 8'h00, tx_ch.echo_byte);
            else
            begin
                want = expected_beats.pop_front();
                check_field("echo_valid", want.echo_valid, tx_ch.echo_valid);
                check_field("echo_byte", want.echo_byte, tx_ch.echo_byte);
                check_field("led_lit", want.led_lit, tx_ch.led_lit);
                check_field("blink_start", want.blink_start, tx_ch.blink_start);
                check_field("blink_digit", want.blink_digit, tx_ch.blink_digit);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [DZ_W-1:0] dz_plan [5];
        dz_plan = '{15'd0, 15'h7FFF, 15'($urandom_range(2, 32766)), 15'd1, DZ_RESET};
        dz_now    = DZ_RESET;
        led_state = 1'b0;
        clear_line();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < STIM_ROWS; i++)
            send_beat(STIM_TABLE[i].data, STIM_TABLE[i].err, STIM_TABLE[i].typed,
                      STIM_TABLE[i].want);

        // random lines under the reset dead zone, then under each new setting
        run_lines(ITEMS_PER_SET);
        foreach (dz_plan[k])
        begin
            write_dead_zone(dz_plan[k]);
            run_lines(ITEMS_PER_SET);
        end

        rx_idle();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes, %0d with receive error, %0d line overflows",
                 n_items, n_rx_errors, n_overflows);
        $display("%0d blink requests, %0d indicator turn-ons, %0d dead zone settings",
                 n_blinks, n_led_on, n_dz_sets);
        if (n_mismatch == 0 && expected_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
